FILE: rtl/core/assert_macros.svh
// Assertion helpers, clocked on clk and held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ubst_pkg.sv
`default_nettype none

package ubst_pkg;

    // Encoding selector codes; 5..7 are taken as UTF-8
    typedef enum logic [2:0] {
        ENC_UTF8   = 3'd0,
        ENC_UCS2LE = 3'd1,
        ENC_UCS2BE = 3'd2,
        ENC_UCS4LE = 3'd3,
        ENC_UCS4BE = 3'd4
    } enc_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_LEAD    = 2'd1,
        ST_UNENCODABLE = 2'd2
    } status_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_IN_ENCODING  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_ENCODING = 2'd1;

    // Result of one input byte: up to eight output bytes plus the new pending buffer
    typedef struct packed {
        logic [7:0][7:0] data;
        logic [3:0]      num;
        status_t         status;
        logic [3:0][7:0] pend;
        logic [2:0]      pend_cnt;
    } ubst_res_t;

endpackage

`default_nettype wire

FILE: rtl/core/ubst_in_if.sv
`default_nettype none

interface ubst_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ubst_out_if.sv
`default_nettype none

interface ubst_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic [1:0] status;

    modport source (output valid, output out_byte, output run_last, output status,
                    input ready);
    modport sink (input valid, input out_byte, input run_last, input status,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ubst_codec.sv
`default_nettype none

module ubst_codec
    import ubst_pkg::*;
(
    input  wire logic [2:0]      in_enc,
    input  wire logic [2:0]      out_enc,
    input  wire logic [3:0][7:0] pend,
    input  wire logic [2:0]      pend_cnt,
    input  wire logic [7:0]      new_byte,
    output ubst_res_t            res
);

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      len;
        logic            ok;
    } enc_out_t;

    function automatic enc_t norm_enc(input logic [2:0] e);
        if (e <= 3'(ENC_UCS4BE))
            return enc_t'(e);
        return ENC_UTF8;
    endfunction

    function automatic enc_out_t encode_cp(input enc_t enc, input logic [31:0] cp);
        enc_out_t   r;
        logic [19:0] v;
        logic [15:0] w0;
        logic [15:0] w1;
        r    = '0;
        r.ok = 1'b1;
        v    = 20'(cp - 32'h0001_0000);
        w0   = {6'b110110, v[19:10]};
        w1   = {6'b110111, v[9:0]};
        case (enc)
            ENC_UTF8:
            begin
                if (cp < 32'h80)
                begin
                    r.b[0] = cp[7:0];
                    r.len  = 3'd1;
                end
                else if (cp < 32'h800)
                begin
                    r.b[0] = {3'b110, cp[10:6]};
                    r.b[1] = {2'b10, cp[5:0]};
                    r.len  = 3'd2;
                end
                else if (cp < 32'h1_0000)
                begin
                    r.b[0] = {4'b1110, cp[15:12]};
                    r.b[1] = {2'b10, cp[11:6]};
                    r.b[2] = {2'b10, cp[5:0]};
                    r.len  = 3'd3;
                end
                else if (cp < 32'h20_0000)
                begin
                    r.b[0] = {5'b11110, cp[20:18]};
                    r.b[1] = {2'b10, cp[17:12]};
                    r.b[2] = {2'b10, cp[11:6]};
                    r.b[3] = {2'b10, cp[5:0]};
                    r.len  = 3'd4;
                end
                else
                begin
                    r.ok = 1'b0;
                end
            end
            ENC_UCS2LE, ENC_UCS2BE:
            begin
                if (cp > 32'h10_FFFF)
                begin
                    r.ok = 1'b0;
                end
                else if (cp > 32'hFFFF)
                begin
                    r.len = 3'd4;
                    if (enc == ENC_UCS2LE)
                        r.b = {w1[15:8], w1[7:0], w0[15:8], w0[7:0]};
                    else
                        r.b = {w1[7:0], w1[15:8], w0[7:0], w0[15:8]};
                end
                else
                begin
                    r.len = 3'd2;
                    if (enc == ENC_UCS2LE)
                        r.b = {16'h0000, cp[15:8], cp[7:0]};
                    else
                        r.b = {16'h0000, cp[7:0], cp[15:8]};
                end
            end
            ENC_UCS4LE:
            begin
                r.len = 3'd4;
                r.b   = cp;
            end
            ENC_UCS4BE:
            begin
                r.len = 3'd4;
                r.b   = {cp[7:0], cp[15:8], cp[23:16], cp[31:24]};
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    enc_t            ie;
    enc_t            oe;
    logic [2:0]      cnt_eff;
    logic [2:0]      cnt;
    logic [3:0][7:0] b;
    logic [15:0]     w1;
    logic [15:0]     w2;
    logic [2:0]      need;
    logic            bad_lead;
    logic            v1;
    logic            v2;
    logic [31:0]     cp1;
    logic [31:0]     cp2;
    logic [2:0]      rest;
    logic            rest_shift;
    enc_out_t        e1;
    enc_out_t        e2;
    logic [2:0]      j;

    always_comb
    begin
        ie      = norm_enc(in_enc);
        oe      = norm_enc(out_enc);
        // a full buffer on entry is dropped
        cnt_eff = (pend_cnt >= 3'd4) ? 3'd0 : pend_cnt;
        cnt     = cnt_eff + 3'd1;
        for (int i = 0; i < 4; i++)
            b[i] = (2'(i) == cnt_eff[1:0]) ? new_byte : pend[i];

        w1 = (ie == ENC_UCS2LE) ? {b[1], b[0]} : {b[0], b[1]};
        w2 = (ie == ENC_UCS2LE) ? {b[3], b[2]} : {b[2], b[3]};

        need       = 3'd1;
        bad_lead   = 1'b0;
        v1         = 1'b0;
        v2         = 1'b0;
        cp1        = '0;
        cp2        = {16'h0000, w2};
        rest       = cnt;
        rest_shift = 1'b0;

        case (ie)
            ENC_UTF8:
            begin
                if (!b[0][7])
                begin
                    need = 3'd1;
                    cp1  = {24'h0, b[0]};
                end
                else if (b[0][7:5] == 3'b110)
                begin
                    need = 3'd2;
                    cp1  = {21'h0, b[0][4:0], b[1][5:0]};
                end
                else if (b[0][7:4] == 4'b1110)
                begin
                    need = 3'd3;
                    cp1  = {16'h0, b[0][3:0], b[1][5:0], b[2][5:0]};
                end
                else if (b[0][7:3] == 5'b11110)
                begin
                    need = 3'd4;
                    cp1  = {11'h0, b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
                end
                else
                begin
                    bad_lead = 1'b1;
                end
                if (!bad_lead && cnt >= need)
                begin
                    v1   = 1'b1;
                    rest = 3'd0;
                end
            end
            ENC_UCS2LE, ENC_UCS2BE:
            begin
                if (cnt >= 3'd2)
                begin
                    if (w1[15:10] != 6'b110110)
                    begin
                        v1   = 1'b1;
                        cp1  = {16'h0000, w1};
                        rest = 3'd0;
                    end
                    else if (cnt == 3'd4)
                    begin
                        v1 = 1'b1;
                        if (w2[15:10] == 6'b110111)
                        begin
                            cp1  = 32'h0001_0000 + {12'h0, w1[9:0], w2[9:0]};
                            rest = 3'd0;
                        end
                        else
                        begin
                            // unpaired leading surrogate goes out alone
                            cp1 = {16'h0000, w1};
                            if (w2[15:10] != 6'b110110)
                            begin
                                v2   = 1'b1;
                                rest = 3'd0;
                            end
                            else
                            begin
                                rest       = 3'd2;
                                rest_shift = 1'b1;
                            end
                        end
                    end
                end
            end
            ENC_UCS4LE, ENC_UCS4BE:
            begin
                if (cnt == 3'd4)
                begin
                    v1   = 1'b1;
                    cp1  = (ie == ENC_UCS4LE) ? b : {b[0], b[1], b[2], b[3]};
                    rest = 3'd0;
                end
            end
            default:
            begin
                rest = cnt;
            end
        endcase

        e1 = encode_cp(oe, cp1);
        e2 = encode_cp(oe, cp2);

        res.data     = '0;
        res.status   = ST_OK;
        res.num      = (v1 ? {1'b0, e1.len} : 4'd0) + (v2 ? {1'b0, e2.len} : 4'd0);
        res.pend     = rest_shift ? {b[3], b[2], b[3], b[2]} : b;
        res.pend_cnt = rest;
        for (int i = 0; i < 8; i++)
        begin
            j = 3'(i) - e1.len;
            if (3'(i) < e1.len)
                res.data[i] = e1.b[2'(i)];
            else if (j < 3'd4)
                res.data[i] = e2.b[j[1:0]];
        end

        if (bad_lead || (v1 && !e1.ok) || (v2 && !e2.ok))
        begin
            // a lone error word replaces anything formed for this byte
            res.status   = bad_lead ? ST_BAD_LEAD : ST_UNENCODABLE;
            res.num      = 4'd1;
            res.data     = '0;
            res.pend_cnt = 3'd0;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/unicode_byte_stream_transcoder_unit.sv
// An accepted byte goes into the input register, then into the burst register once that
// register is free; its result words are presented from the burst register.
// Throughput: one result word per cycle while the receiver is ready; n, the number of words
// a byte produces (0 to 8, 4 for UTF-8 to UCS-4), is held in the burst count register.
// A new byte is taken into the input register while the previous burst still drains.
// Reset clears both encodings to UTF-8, empties the pending buffer and both stages.
`default_nettype none

`include "assert_macros.svh"

module unicode_byte_stream_transcoder_unit
    import ubst_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    ubst_in_if.sink                    in_ch,
    ubst_out_if.source                 out_ch
);

    logic [2:0]      in_enc_reg;
    logic [2:0]      out_enc_reg;
    logic [3:0][7:0] pend_bytes_reg;
    logic [2:0]      pend_cnt_reg;

    logic            a_valid_reg;
    logic [7:0]      a_byte_reg;

    logic [7:0][7:0] burst_reg;
    logic [3:0]      burst_cnt_reg;
    status_t         burst_status_reg;

    ubst_res_t       res;
    logic            take;
    logic            b_free;
    logic            load;
    logic            cfg_hit;

    ubst_codec u_codec (
        .in_enc   (in_enc_reg),
        .out_enc  (out_enc_reg),
        .pend     (pend_bytes_reg),
        .pend_cnt (pend_cnt_reg),
        .new_byte (a_byte_reg),
        .res      (res)
    );

    assign take    = out_ch.valid && out_ch.ready;
    assign b_free  = (burst_cnt_reg == 4'd0) || (take && burst_cnt_reg == 4'd1);
    assign load    = a_valid_reg && b_free;
    assign cfg_hit = cfg_wr_en &&
                     (cfg_index == REG_IN_ENCODING || cfg_index == REG_OUT_ENCODING);

    assign in_ch.ready     = !a_valid_reg || b_free;
    assign out_ch.valid    = (burst_cnt_reg != 4'd0);
    assign out_ch.out_byte = burst_reg[0];
    assign out_ch.run_last = (burst_cnt_reg == 4'd1);
    assign out_ch.status   = burst_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_enc_reg  <= 3'(ENC_UTF8);
            out_enc_reg <= 3'(ENC_UTF8);
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == REG_IN_ENCODING)
                in_enc_reg <= cfg_wr_data;
            if (cfg_index == REG_OUT_ENCODING)
                out_enc_reg <= cfg_wr_data;
        end
    end

    // pending buffer advances only when a byte moves into the burst register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_cnt_reg <= 3'd0;
        else if (cfg_hit)
            pend_cnt_reg <= 3'd0;
        else if (load)
            pend_cnt_reg <= res.pend_cnt;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            pend_bytes_reg <= res.pend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (in_ch.valid && in_ch.ready)
            a_valid_reg <= 1'b1;
        else if (load)
            a_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
            a_byte_reg <= in_ch.in_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            burst_cnt_reg <= 4'd0;
        else if (load)
            burst_cnt_reg <= res.num;
        else if (take)
            burst_cnt_reg <= burst_cnt_reg - 4'd1;
    end

    // shift the burst down one word per take
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            burst_reg        <= res.data;
            burst_status_reg <= res.status;
        end
        else if (take)
        begin
            burst_reg <= {8'h00, burst_reg[7:1]};
        end
    end

    `ASSERT_IMPLIES(a_error_alone, out_ch.valid && (out_ch.status != ST_OK), out_ch.run_last && (out_ch.out_byte == 8'h00), "error word not alone in its run")
    `ASSERT_NEXT(a_run_continues, take && !out_ch.run_last, out_ch.valid, "run ended before its last word")
    `ASSERT_NEXT(a_cfg_restart, cfg_hit, pend_cnt_reg == 3'd0, "pending buffer kept across register write")
    `ASSERT_IMPLIES(a_pend_bound, a_valid_reg, pend_cnt_reg <= 3'd3, "pending buffer overfilled")

endmodule

`default_nettype wire

FILE: tb/sv/unicode_byte_stream_transcoder_unit_tb.sv
module unicode_byte_stream_transcoder_unit_tb;
    import ubst_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int HOLD_CYCLES    = 90;
    localparam int SEG_BYTES      = 27;

    localparam logic [CFG_IDX_W-1:0]  REG_SPARE_A  = 2'd2;
    localparam logic [CFG_IDX_W-1:0]  REG_SPARE_B  = 2'd3;
    localparam logic [CFG_DATA_W-1:0] ENC_ALIAS_LO = 3'd5;
    localparam logic [CFG_DATA_W-1:0] ENC_ALIAS_HI = 3'd7;

    localparam logic [31:0] EDGE_POINTS [11] = '{
        32'h0, 32'h7f, 32'h80, 32'h7ff, 32'h800, 32'hffff, 32'h10000,
        32'h10ffff, 32'h1fffff, 32'h200000, 32'hffffffff
    };

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        status_t    status;
    } tx_word_t;

    typedef logic [7:0] byte_q_t [$];

    class transcode_scoreboard;
        logic [2:0] in_sel;
        logic [2:0] out_sel;
        logic [7:0] pend [4];
        int         pend_cnt;
        tx_word_t   due_words [$];
        int         errors;

        function void clear();
            in_sel = ENC_UTF8;
            out_sel = ENC_UTF8;
            pend_cnt = 0;
            due_words.delete();
            errors = 0;
        endfunction

        function enc_t norm(logic [2:0] sel);
            return (sel > ENC_UCS4BE) ? ENC_UTF8 : enc_t'(sel);
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_IN_ENCODING)
            begin
                in_sel = val;
                pend_cnt = 0;
            end
            else if (idx == REG_OUT_ENCODING)
            begin
                out_sel = val;
                pend_cnt = 0;
            end
        endfunction

        // Bytes taken from the pending buffer, 0 if incomplete, -1 on a bad UTF-8 lead.
        function int decode_point(enc_t e, output logic [31:0] cp);
            logic [31:0] b0;
            logic [31:0] w1;
            logic [31:0] w2;
            cp = '0;
            if (pend_cnt < 1)
                return 0;
            case (e)
                ENC_UTF8:
                begin
                    b0 = 32'(pend[0]);
                    if (b0 < 32'h80)
                    begin
                        cp = b0;
                        return 1;
                    end
                    if ((b0 & 32'he0) == 32'hc0)
                    begin
                        if (pend_cnt < 2)
                            return 0;
                        cp = ((b0 & 32'h1f) << 6) | 32'(pend[1] & 8'h3f);
                        return 2;
                    end
                    if ((b0 & 32'hf0) == 32'he0)
                    begin
                        if (pend_cnt < 3)
                            return 0;
                        cp = ((b0 & 32'h0f) << 12) | (32'(pend[1] & 8'h3f) << 6)
                           | 32'(pend[2] & 8'h3f);
                        return 3;
                    end
                    if ((b0 & 32'hf8) == 32'hf0)
                    begin
                        if (pend_cnt < 4)
                            return 0;
                        cp = ((b0 & 32'h07) << 18) | (32'(pend[1] & 8'h3f) << 12)
                           | (32'(pend[2] & 8'h3f) << 6) | 32'(pend[3] & 8'h3f);
                        return 4;
                    end
                    return -1;
                end
                ENC_UCS2LE, ENC_UCS2BE:
                begin
                    if (pend_cnt < 2)
                        return 0;
                    w1 = (e == ENC_UCS2LE) ? 32'({pend[1], pend[0]}) : 32'({pend[0], pend[1]});
                    if (w1 < 32'hd800 || w1 > 32'hdbff)
                    begin
                        cp = w1;
                        return 2;
                    end
                    if (pend_cnt < 4)
                        return 0;
                    w2 = (e == ENC_UCS2LE) ? 32'({pend[3], pend[2]}) : 32'({pend[2], pend[3]});
                    // unpaired leading surrogate: emit it alone, follower is decoded anew
                    if (w2 < 32'hdc00 || w2 > 32'hdfff)
                    begin
                        cp = w1;
                        return 2;
                    end
                    cp = 32'h10000 + ((w1 - 32'hd800) << 10) + (w2 - 32'hdc00);
                    return 4;
                end
                ENC_UCS4LE:
                begin
                    if (pend_cnt < 4)
                        return 0;
                    cp = {pend[3], pend[2], pend[1], pend[0]};
                    return 4;
                end
                default:
                begin
                    if (pend_cnt < 4)
                        return 0;
                    cp = {pend[0], pend[1], pend[2], pend[3]};
                    return 4;
                end
            endcase
        endfunction

        // Bytes written to o, 0 when the code point has no form in this encoding.
        function int encode_point(enc_t e, logic [31:0] cp, output logic [7:0] o [4]);
            logic [15:0] w [2];
            logic [31:0] v;
            int          nw;
            foreach (o[i])
                o[i] = '0;
            case (e)
                ENC_UTF8:
                begin
                    if (cp < 32'h80)
                    begin
                        o[0] = cp[7:0];
                        return 1;
                    end
                    if (cp < 32'h800)
                    begin
                        o[0] = 8'(cp >> 6) | 8'hc0;
                        o[1] = 8'(cp & 32'h3f) | 8'h80;
                        return 2;
                    end
                    if (cp < 32'h10000)
                    begin
                        o[0] = 8'(cp >> 12) | 8'he0;
                        o[1] = 8'((cp >> 6) & 32'h3f) | 8'h80;
                        o[2] = 8'(cp & 32'h3f) | 8'h80;
                        return 3;
                    end
                    if (cp < 32'h200000)
                    begin
                        o[0] = 8'(cp >> 18) | 8'hf0;
                        o[1] = 8'((cp >> 12) & 32'h3f) | 8'h80;
                        o[2] = 8'((cp >> 6) & 32'h3f) | 8'h80;
                        o[3] = 8'(cp & 32'h3f) | 8'h80;
                        return 4;
                    end
                    return 0;
                end
                ENC_UCS2LE, ENC_UCS2BE:
                begin
                    if (cp > 32'h10ffff)
                        return 0;
                    if (cp > 32'hffff)
                    begin
                        v = cp - 32'h10000;
                        w[0] = 16'hd800 | 16'(v >> 10);
                        w[1] = 16'hdc00 | 16'(v & 32'h3ff);
                        nw = 2;
                    end
                    else
                    begin
                        w[0] = cp[15:0];
                        w[1] = '0;
                        nw = 1;
                    end
                    for (int i = 0; i < nw; i++)
                    begin
                        o[2*i]   = (e == ENC_UCS2LE) ? w[i][7:0] : w[i][15:8];
                        o[2*i+1] = (e == ENC_UCS2LE) ? w[i][15:8] : w[i][7:0];
                    end
                    return 2 * nw;
                end
                ENC_UCS4LE:
                begin
                    {o[3], o[2], o[1], o[0]} = cp;
                    return 4;
                end
                default:
                begin
                    {o[0], o[1], o[2], o[3]} = cp;
                    return 4;
                end
            endcase
        endfunction

        function void predict_byte(logic [7:0] b);
            enc_t        ie;
            enc_t        oe;
            logic [31:0] cp;
            logic [7:0]  eb [4];
            int          used;
            int          ne;
            tx_word_t    step_q [$];
            ie = norm(in_sel);
            oe = norm(out_sel);
            if (pend_cnt >= 4)
                pend_cnt = 0;
            pend[pend_cnt] = b;
            pend_cnt++;
            while (pend_cnt > 0)
            begin
                used = decode_point(ie, cp);
                if (used == 0)
                    break;
                ne = 0;
                if (used > 0)
                    ne = encode_point(oe, cp, eb);
                // an error word stands alone: drop whatever this byte formed so far
                if (ne == 0)
                begin
                    pend_cnt = 0;
                    due_words.push_back('{8'h00, 1'b1,
                                          (used < 0) ? ST_BAD_LEAD : ST_UNENCODABLE});
                    return;
                end
                for (int i = 0; i < ne && step_q.size() < 8; i++)
                    step_q.push_back('{eb[i], 1'b0, ST_OK});
                if (used >= pend_cnt)
                    pend_cnt = 0;
                else
                begin
                    for (int k = 0; k < pend_cnt - used; k++)
                        pend[k] = pend[k + used];
                    pend_cnt -= used;
                end
            end
            if (step_q.size() > 0)
                step_q[step_q.size() - 1].run_last = 1'b1;
            foreach (step_q[i])
                due_words.push_back(step_q[i]);
        endfunction

        task report(string msg);
            $display("tb: mismatch: %s", msg);
            errors++;
        endtask

        task check_word(logic [7:0] ob, logic last, logic [1:0] st);
            tx_word_t want;
            if (due_words.size() == 0)
                report($sformatf("unexpected word byte %02h last %0d status %0d", ob, last, st));
            else
            begin
                want = due_words.pop_front();
                if (ob !== want.out_byte)
                    report($sformatf("out_byte %02h, want %02h", ob, want.out_byte));
                if (last !== want.run_last)
                    report($sformatf("run_last %0d, want %0d", last, want.run_last));
                if (st !== want.status)
                    report($sformatf("status %0d, want %0d", st, want.status));
            end
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;

    ubst_in_if  in_ch ();
    ubst_out_if out_ch ();

    transcode_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles  = 0;
    bit hold_req      = 1'b0;

    unicode_byte_stream_transcoder_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                sb.predict_byte(in_ch.in_byte);
            if (out_ch.valid && out_ch.ready)
                sb.check_word(out_ch.out_byte, out_ch.run_last, out_ch.status);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            // hold ready low so the block backs up and stalls its input
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Entered and left at a falling edge; valid stays high on exit.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.in_byte <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_seq(input byte_q_t seq);
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    // Drop valid and wait until every due word has come and the last byte has settled.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.due_words.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_point(enc_t ie);
        logic [31:0] cp;
        case ($urandom_range(9))
            0, 1, 2: cp = $urandom_range(32'h7f);
            3:       cp = $urandom_range(32'h7ff, 32'h80);
            4:       cp = $urandom_range(32'hffff, 32'h800);
            5:       cp = $urandom_range(32'h10ffff, 32'h10000);
            6:       cp = $urandom_range(32'hdfff, 32'hd800);
            7:       cp = $urandom_range(32'h1fffff, 32'h110000);
            8:       cp = $urandom;
            default: cp = EDGE_POINTS[$urandom_range(10)];
        endcase
        // keep the point within what the input form can carry
        if (ie == ENC_UTF8)
            cp = cp & 32'h1fffff;
        else if ((ie == ENC_UCS2LE || ie == ENC_UCS2BE) && cp > 32'h10ffff)
            cp = cp % 32'h110000;
        return cp;
    endfunction

    task automatic run_segment(input int seg_no, input bit with_hold);
        logic [CFG_DATA_W-1:0] in_val;
        logic [CFG_DATA_W-1:0] out_val;
        enc_t                  ie;
        logic [31:0]           cp;
        logic [7:0]            eb [4];
        int                    ne;
        int                    keep;
        int                    sent;
        int                    r;
        bit                    held;
        drain();
        if (seg_no == 0)
        begin
            in_val = ENC_ALIAS_HI;
            out_val = ENC_ALIAS_LO;
        end
        else if (seg_no == 1)
        begin
            in_val = ENC_UTF8;
            out_val = ENC_UCS4BE;
        end
        else
        begin
            in_val = 3'($urandom_range(7));
            out_val = 3'($urandom_range(7));
        end
        write_reg(REG_IN_ENCODING, in_val);
        write_reg(REG_OUT_ENCODING, out_val);
        ie = sb.norm(in_val);
        sent = 0;
        held = 1'b0;
        while (sent < SEG_BYTES)
        begin
            if (with_hold && !held && sent >= 10)
            begin
                hold_req = 1'b1;
                held = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 10)
            begin
                send_byte(8'($urandom_range(255)));
                sent++;
            end
            else
            begin
                cp = pick_point(ie);
                ne = sb.encode_point(ie, cp, eb);
                keep = ne;
                // cut a sequence short now and then
                if (r < 16 && ne > 1)
                    keep = $urandom_range(ne - 1, 1);
                for (int i = 0; i < keep; i++)
                    send_byte(eb[i]);
                sent += keep;
            end
        end
    endtask

    initial
    begin : main
        int seg;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wr_data = '0;
        in_ch.valid = 1'b0;
        in_ch.in_byte = '0;
        sb.clear();
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // UTF-8 both ways: ASCII ends, bad leads, two-, three- and four-byte forms
        send_seq('{8'h00, 8'h7f, 8'h80, 8'hff, 8'hc3, 8'ha9, 8'he2, 8'h82, 8'hac,
                   8'hf0, 8'h9f, 8'h98, 8'h80});
        drain();
        write_reg(REG_SPARE_A, ENC_UCS4BE);
        write_reg(REG_SPARE_B, ENC_UCS2LE);
        write_reg(REG_IN_ENCODING, ENC_UCS4BE);
        send_seq('{8'h00, 8'h20, 8'h00, 8'h00});
        drain();
        write_reg(REG_IN_ENCODING, ENC_UCS4LE);
        write_reg(REG_OUT_ENCODING, ENC_UCS2BE);
        send_seq('{8'h00, 8'h00, 8'h11, 8'h00});
        drain();
        write_reg(REG_IN_ENCODING, ENC_UCS2BE);
        write_reg(REG_OUT_ENCODING, ENC_UCS4LE);
        send_seq('{8'hd8, 8'h00, 8'h00, 8'h41});

        seg = 0;
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 52 : 0;
            recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 15 : 0;
            for (int k = 0; k < 3; k++)
            begin
                run_segment(seg, phase == 2 && k == 1);
                seg++;
            end
        end

        drain();
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
